[sv/variable_frame_animation_sequencer_unit_defines.svh]
// ----------------------------------------------------------------------------
// Frame sequencer assertion macros
// Concurrent check macros used by the sequencer top level; define ASSERT_OFF
// to compile them out.
// ----------------------------------------------------------------------------
`ifndef VARIABLE_FRAME_ANIMATION_SEQUENCER_UNIT_DEFINES_SVH
`define VARIABLE_FRAME_ANIMATION_SEQUENCER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication on clk, held off during reset
`define VFAS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vfas: check failed");

// next-cycle implication on clk, held off during reset
`define VFAS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vfas: check failed");

`else

`define VFAS_ASSERT_IMP(lbl, ante, cons)
`define VFAS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

[sv/vfas_pkg.sv]
// ----------------------------------------------------------------------------
// Frame sequencer package
// Sizes, command and register codes, microcode table and time helpers.
// ----------------------------------------------------------------------------
package vfas_pkg;

  localparam int MAX_FRAMES = 64;
  localparam int TIME_BITS  = 32;

  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int TIME_W     = TIME_BITS;
  localparam int CMD_W      = 2;
  localparam int ELAPSED_W  = 16;
  localparam int IDX_W      = 6;
  localparam int DUR_W      = 16;
  localparam int FC_W       = 7;
  localparam int SPEED_W    = 16;
  localparam int OUT_FR_W   = 6;
  localparam int OUT_POS_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int FRAC_BITS  = 8;
  localparam int PROD_W     = ELAPSED_W + SPEED_W;
  localparam int SCALED_W   = PROD_W - FRAC_BITS;
  localparam int WIDE_W     = (TIME_W > SCALED_W) ? TIME_W : SCALED_W;
  localparam int CNT_W      = $clog2(TIME_W);
  localparam int PC_W       = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_LOAD = 2'd1,
    CMD_SEEK = 2'd2,
    CMD_RUN  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_COUNT = 2'd0,
    CFG_LOOP_ENABLE = 2'd1,
    CFG_SPEED       = 2'd2
  } cfg_reg_t;

  // datapath actions, one per control word
  typedef enum logic [4:0] {
    ACT_NOP,
    ACT_IDLE,
    ACT_RD_LAST,
    ACT_ADD,
    ACT_WALK_INIT,
    ACT_RD_WALK,
    ACT_WALK_STEP,
    ACT_SET_FRAME,
    ACT_MOD_INIT,
    ACT_MOD_STEP,
    ACT_POS_REM,
    ACT_POS_ZERO,
    ACT_STOP,
    ACT_SEEK_CLAMP,
    ACT_SEEK_RD,
    ACT_SEEK_POS,
    ACT_LOAD,
    ACT_LOAD_WR,
    ACT_SET_RUN,
    ACT_EMIT
  } act_t;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_DISPATCH,
    C_NOT_RUN,
    C_END_PASSED,
    C_WRAP,
    C_WALK_END,
    C_WALK_MORE,
    C_TOTAL_ZERO,
    C_MOD_MORE,
    C_SEEK_ZERO,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    act_t            act;
    cond_t           cond;
    logic            hold;    // stay on this step while the condition is false
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic not_run;
    logic end_passed;
    logic wrap;
    logic walk_end;
    logic walk_more;
    logic total_zero;
    logic mod_more;
    logic seek_zero;
    logic out_free;
    logic in_fire;
    cmd_t cmd;
  } status_t;

  localparam logic [PC_W-1:0] PC_IDLE      = 5'd0;
  localparam logic [PC_W-1:0] PC_TICK      = 5'd1;
  localparam logic [PC_W-1:0] PC_TICK_ADD  = 5'd2;
  localparam logic [PC_W-1:0] PC_TICK_END  = 5'd3;
  localparam logic [PC_W-1:0] PC_TICK_WRAP = 5'd4;
  localparam logic [PC_W-1:0] PC_WALK      = 5'd5;
  localparam logic [PC_W-1:0] PC_WALK_CMP  = 5'd6;
  localparam logic [PC_W-1:0] PC_SET_FRAME = 5'd7;
  localparam logic [PC_W-1:0] PC_MOD       = 5'd8;
  localparam logic [PC_W-1:0] PC_MOD_STEP  = 5'd9;
  localparam logic [PC_W-1:0] PC_MOD_DONE  = 5'd10;
  localparam logic [PC_W-1:0] PC_POS_ZERO  = 5'd11;
  localparam logic [PC_W-1:0] PC_STOP      = 5'd12;
  localparam logic [PC_W-1:0] PC_SEEK      = 5'd13;
  localparam logic [PC_W-1:0] PC_SEEK_RD   = 5'd14;
  localparam logic [PC_W-1:0] PC_SEEK_POS  = 5'd15;
  localparam logic [PC_W-1:0] PC_SEEK_ZERO = 5'd16;
  localparam logic [PC_W-1:0] PC_LOAD      = 5'd17;
  localparam logic [PC_W-1:0] PC_LOAD_WR   = 5'd18;
  localparam logic [PC_W-1:0] PC_RUN       = 5'd19;
  localparam logic [PC_W-1:0] PC_EMIT      = 5'd20;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{ACT_NOP, C_ALWAYS, 1'b0, PC_IDLE};
    case (pc)
      PC_IDLE:      w = '{ACT_IDLE,       C_DISPATCH,   1'b0, PC_IDLE};
      PC_TICK:      w = '{ACT_RD_LAST,    C_NOT_RUN,    1'b0, PC_EMIT};
      PC_TICK_ADD:  w = '{ACT_ADD,        C_NEVER,      1'b0, PC_IDLE};
      PC_TICK_END:  w = '{ACT_NOP,        C_END_PASSED, 1'b0, PC_STOP};
      PC_TICK_WRAP: w = '{ACT_WALK_INIT,  C_WRAP,       1'b0, PC_MOD};
      PC_WALK:      w = '{ACT_RD_WALK,    C_WALK_END,   1'b0, PC_SET_FRAME};
      PC_WALK_CMP:  w = '{ACT_WALK_STEP,  C_WALK_MORE,  1'b0, PC_WALK};
      PC_SET_FRAME: w = '{ACT_SET_FRAME,  C_ALWAYS,     1'b0, PC_EMIT};
      PC_MOD:       w = '{ACT_MOD_INIT,   C_TOTAL_ZERO, 1'b0, PC_POS_ZERO};
      PC_MOD_STEP:  w = '{ACT_MOD_STEP,   C_MOD_MORE,   1'b0, PC_MOD_STEP};
      PC_MOD_DONE:  w = '{ACT_POS_REM,    C_ALWAYS,     1'b0, PC_WALK};
      PC_POS_ZERO:  w = '{ACT_POS_ZERO,   C_ALWAYS,     1'b0, PC_WALK};
      PC_STOP:      w = '{ACT_STOP,       C_ALWAYS,     1'b0, PC_SEEK_RD};
      PC_SEEK:      w = '{ACT_SEEK_CLAMP, C_NEVER,      1'b0, PC_IDLE};
      PC_SEEK_RD:   w = '{ACT_SEEK_RD,    C_SEEK_ZERO,  1'b0, PC_SEEK_ZERO};
      PC_SEEK_POS:  w = '{ACT_SEEK_POS,   C_ALWAYS,     1'b0, PC_EMIT};
      PC_SEEK_ZERO: w = '{ACT_POS_ZERO,   C_ALWAYS,     1'b0, PC_EMIT};
      PC_LOAD:      w = '{ACT_LOAD,       C_NEVER,      1'b0, PC_IDLE};
      PC_LOAD_WR:   w = '{ACT_LOAD_WR,    C_ALWAYS,     1'b0, PC_EMIT};
      PC_RUN:       w = '{ACT_SET_RUN,    C_NEVER,      1'b0, PC_IDLE};
      PC_EMIT:      w = '{ACT_EMIT,       C_OUT_FREE,   1'b1, PC_IDLE};
      default:      w = '{ACT_NOP,        C_ALWAYS,     1'b0, PC_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [PC_W-1:0] dispatch(input cmd_t cmd);
    logic [PC_W-1:0] pc;
    pc = PC_TICK;
    unique case (cmd)
      CMD_TICK: pc = PC_TICK;
      CMD_LOAD: pc = PC_LOAD;
      CMD_SEEK: pc = PC_SEEK;
      CMD_RUN:  pc = PC_RUN;
      default:  pc = PC_TICK;
    endcase
    return pc;
  endfunction

  // saturating add, clamps at the top of the time range
  function automatic logic [TIME_W-1:0] sat_add(input logic [WIDE_W-1:0] a,
                                                input logic [WIDE_W-1:0] b);
    logic [WIDE_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (|sum[WIDE_W:TIME_W]) begin
      return '1;
    end
    return TIME_W'(sum);
  endfunction

endpackage

[sv/vfas_if.sv]
// ----------------------------------------------------------------------------
// Frame sequencer channels
// Valid/ready interfaces for the command and result channels.
// ----------------------------------------------------------------------------
interface vfas_in_if
  import vfas_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [ELAPSED_W-1:0] elapsed;
  logic [IDX_W-1:0]     frame_index;
  logic [DUR_W-1:0]     duration;
  logic                 run;

  modport source (output valid, cmd, elapsed, frame_index, duration, run, input ready);
  modport sink   (input valid, cmd, elapsed, frame_index, duration, run, output ready);
endinterface

interface vfas_out_if
  import vfas_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [OUT_FR_W-1:0]  frame;
  logic                 playing;
  logic [OUT_POS_W-1:0] position;

  modport source (output valid, frame, playing, position, input ready);
  modport sink   (input valid, frame, playing, position, output ready);
endinterface

[sv/vfas_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vfas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/vfas_seq.sv]
// ----------------------------------------------------------------------------
// Frame sequencer microcode engine
// Step counter over the control store, with conditional and dispatch jumps.
// ----------------------------------------------------------------------------
module vfas_seq
  import vfas_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  status_t st,
  output uword_t  uw
);

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            take;

  assign uw = ucode(pc_r);

  always_comb begin
    unique case (uw.cond)
      C_NEVER:      take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_DISPATCH:   take = st.in_fire;
      C_NOT_RUN:    take = st.not_run;
      C_END_PASSED: take = st.end_passed;
      C_WRAP:       take = st.wrap;
      C_WALK_END:   take = st.walk_end;
      C_WALK_MORE:  take = st.walk_more;
      C_TOTAL_ZERO: take = st.total_zero;
      C_MOD_MORE:   take = st.mod_more;
      C_SEEK_ZERO:  take = st.seek_zero;
      C_OUT_FREE:   take = st.out_free;
      default:      take = 1'b0;
    endcase
  end

  always_comb begin
    if (uw.cond == C_DISPATCH) begin
      pc_nxt = st.in_fire ? dispatch(st.cmd) : pc_r;
    end else if (take) begin
      pc_nxt = uw.target;
    end else if (uw.hold) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

[sv/variable_frame_animation_sequencer_unit.sv]
// A tick on a wrap runs 32 remainder steps. Throughput: one transaction at a time,
// next accepted the cycle after the result registers. Reset: synchronous rst_n gives
// position 0, frame 0, running 1, sum 0, frame_count 1, looping on, speed 1.0.
// ----------------------------------------------------------------------------
// Variable frame animation sequencer
// Microcoded sequencer over a frame end-time RAM: load, seek, tick, set run.
// ----------------------------------------------------------------------------
`include "variable_frame_animation_sequencer_unit_defines.svh"

module variable_frame_animation_sequencer_unit
  import vfas_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  vfas_in_if.sink               in_if,
  vfas_out_if.source            out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic [FC_W-1:0]    frame_count_r;
  logic               loop_enable_r;
  logic [SPEED_W-1:0] speed_r;

  // captured transaction payload
  logic [ELAPSED_W-1:0] elapsed_r;
  logic [IDX_W-1:0]     idx_r;
  logic [DUR_W-1:0]     dur_r;
  logic                 run_r;

  // play state
  logic [TIME_W-1:0]  pos_r;
  logic [TIME_W-1:0]  load_sum_r;
  logic [FRAME_W-1:0] frame_r;
  logic               running_r;

  // working registers
  logic [TIME_W-1:0]  total_r;
  logic [TIME_W-1:0]  rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [PROD_W-1:0]  prod_r;
  logic [FRAME_W-1:0] walk_f_r;
  logic [FRAME_W-1:0] seek_f_r;

  // result register
  logic                 out_valid_r;
  logic [OUT_FR_W-1:0]  out_frame_r;
  logic                 out_playing_r;
  logic [OUT_POS_W-1:0] out_pos_r;

  logic [FRAME_W-1:0] last_frame;
  logic [FRAME_W-1:0] seek_clamp;
  logic [TIME_W:0]    rem_sh;
  logic [FRAME_W-1:0] ram_raddr;
  logic [TIME_W-1:0]  ram_rdata;
  logic               ram_we;
  logic               in_fire;
  logic               out_free;
  status_t            st;
  uword_t             uw;

  // --------------------------------------------------------------------------
  // Microcode engine
  // --------------------------------------------------------------------------
  vfas_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .uw    (uw)
  );

  // --------------------------------------------------------------------------
  // End-time store: entry f holds the running end time of frame f
  // --------------------------------------------------------------------------
  vfas_ram #(
    .WIDTH (TIME_W),
    .DEPTH (MAX_FRAMES)
  ) u_end_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (FRAME_W'(idx_r)),
    .wdata (load_sum_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Write only addressed entries that exist; loads beyond the table drop.
  assign ram_we = (uw.act == ACT_LOAD_WR) && (int'(idx_r) < MAX_FRAMES);

  always_comb begin
    unique case (uw.act)
      ACT_RD_WALK: ram_raddr = walk_f_r;
      ACT_SEEK_RD: ram_raddr = FRAME_W'(seek_f_r - 1'b1);
      default:     ram_raddr = last_frame;
    endcase
  end

  // --------------------------------------------------------------------------
  // Frames in use, as the index of the last frame (count clamped to 1..max)
  // --------------------------------------------------------------------------
  always_comb begin
    if (frame_count_r == '0) begin
      last_frame = '0;
    end else if (int'(frame_count_r) > MAX_FRAMES) begin
      last_frame = FRAME_W'(MAX_FRAMES - 1);
    end else begin
      last_frame = FRAME_W'(frame_count_r - 1'b1);
    end
  end

  // Seek target: out-of-range frames land on the last frame.
  always_comb begin
    if (int'(idx_r) > int'(last_frame)) begin
      seek_clamp = last_frame;
    end else begin
      seek_clamp = FRAME_W'(idx_r);
    end
  end

  // One restoring remainder step: shift in the next dividend bit.
  assign rem_sh = {rem_r, pos_r[TIME_W-1]};

  // --------------------------------------------------------------------------
  // Handshake and status toward the sequencer
  // --------------------------------------------------------------------------
  assign in_if.ready = (uw.act == ACT_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;

  always_comb begin
    st.not_run    = !running_r;
    st.end_passed = (pos_r > total_r) && !loop_enable_r;
    st.wrap       = loop_enable_r && (pos_r >= total_r);
    st.walk_end   = (walk_f_r >= last_frame);
    st.walk_more  = (pos_r >= ram_rdata);
    st.total_zero = (total_r == '0);
    st.mod_more   = (cnt_r != CNT_W'(TIME_W - 1));
    st.seek_zero  = (seek_f_r == '0);
    st.out_free   = out_free;
    st.in_fire    = in_fire;
    st.cmd        = cmd_t'(in_if.cmd);
  end

  // --------------------------------------------------------------------------
  // Configuration writes; unknown indexes drop
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FC_W'(1);
      loop_enable_r <= 1'b1;
      speed_r       <= SPEED_W'(1 << FRAC_BITS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_COUNT: frame_count_r <= FC_W'(cfg_wdata);
        CFG_LOOP_ENABLE: loop_enable_r <= cfg_wdata[0];
        CFG_SPEED:       speed_r       <= SPEED_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Capture the accepted transaction
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      elapsed_r <= in_if.elapsed;
      idx_r     <= in_if.frame_index;
      dur_r     <= in_if.duration;
      run_r     <= in_if.run;
    end
  end

  // --------------------------------------------------------------------------
  // Play state, driven by the current control word
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      load_sum_r <= '0;
      frame_r    <= '0;
      running_r  <= 1'b1;
    end else begin
      case (uw.act)
        // add scaled elapsed time, saturating
        ACT_ADD:       pos_r <= sat_add(WIDE_W'(pos_r),
                                        WIDE_W'(prod_r[PROD_W-1:FRAC_BITS]));
        ACT_SET_FRAME: frame_r <= walk_f_r;
        // shift the dividend out of the position as the remainder builds
        ACT_MOD_STEP:  pos_r <= pos_r << 1;
        ACT_POS_REM:   pos_r <= rem_r;
        ACT_POS_ZERO:  pos_r <= '0;
        // end passed with looping off: stop, then seek to the last frame
        ACT_STOP:      running_r <= 1'b0;
        ACT_SEEK_RD:   frame_r <= seek_f_r;
        // frame start is the previous end plus one unit
        ACT_SEEK_POS:  pos_r <= sat_add(WIDE_W'(ram_rdata), WIDE_W'(1));
        // frame zero restarts the running sum
        ACT_LOAD: begin
          if (idx_r == '0) begin
            load_sum_r <= TIME_W'(dur_r);
          end else begin
            load_sum_r <= sat_add(WIDE_W'(load_sum_r), WIDE_W'(dur_r));
          end
        end
        ACT_SET_RUN:   running_r <= run_r;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Working registers: product, total, remainder unit, frame walk
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (uw.act)
      ACT_RD_LAST: prod_r <= PROD_W'(elapsed_r) * PROD_W'(speed_r);
      ACT_ADD:     total_r <= ram_rdata;
      // a stale frame from a larger count restarts the walk at zero
      ACT_WALK_INIT: begin
        if (frame_r > last_frame) begin
          walk_f_r <= '0;
        end else begin
          walk_f_r <= frame_r;
        end
      end
      ACT_WALK_STEP: begin
        if (pos_r >= ram_rdata) begin
          walk_f_r <= walk_f_r + 1'b1;
        end
      end
      ACT_MOD_INIT: begin
        rem_r    <= '0;
        cnt_r    <= '0;
        walk_f_r <= '0;
      end
      ACT_MOD_STEP: begin
        if (rem_sh >= {1'b0, total_r}) begin
          rem_r <= TIME_W'(rem_sh - {1'b0, total_r});
        end else begin
          rem_r <= TIME_W'(rem_sh);
        end
        cnt_r <= cnt_r + 1'b1;
      end
      ACT_STOP:       seek_f_r <= last_frame;
      ACT_SEEK_CLAMP: seek_f_r <= seek_clamp;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Result register: load on the emit step once the slot is free
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((uw.act == ACT_EMIT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((uw.act == ACT_EMIT) && out_free) begin
      out_frame_r   <= OUT_FR_W'(frame_r);
      out_playing_r <= running_r;
      out_pos_r     <= OUT_POS_W'(pos_r);
    end
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.frame    = out_frame_r;
  assign out_if.playing  = out_playing_r;
  assign out_if.position = out_pos_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  // walk never runs past the last frame in use
  `VFAS_ASSERT_IMP(a_walk_bound, uw.act == ACT_SET_FRAME, walk_f_r <= last_frame)
  // seek target is always clamped into range
  `VFAS_ASSERT_IMP(a_seek_bound, uw.act == ACT_SEEK_RD, seek_f_r <= last_frame)
  // partial remainder stays below a nonzero total
  `VFAS_ASSERT_IMP(a_rem_bound, uw.act == ACT_MOD_STEP, rem_r < total_r)
  // a stop clears the run flag for the result that follows
  `VFAS_ASSERT_NXT(a_stop_clears, uw.act == ACT_STOP, !running_r)

endmodule

[tb/sv/variable_frame_animation_sequencer_unit_tb.sv]
// ----------------------------------------------------------------------------
// Frame sequencer testbench
// Sends load, seek, tick and run-flag transactions to the sequencer and
// compares every status it returns with a predicted copy of the play state.
// It covers a short directed part on the corner cases of the playback rules,
// then random playback under many register settings, with random idling on
// both channels, a stretch without idling and one long output stall.
// ----------------------------------------------------------------------------
module variable_frame_animation_sequencer_unit_tb import vfas_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_HOLD    = 400;   // cycles the status sink holds off once
  localparam int IDLE_PERCENT = 31;
  localparam int TAIL_CYCLES  = 60;
  // index that maps to no register; writes to it must be dropped
  localparam cfg_reg_t CFG_SPARE = cfg_reg_t'(2'd3);

  typedef struct packed {
    cmd_t                 cmd;
    logic [ELAPSED_W-1:0] elapsed;
    logic [IDX_W-1:0]     frame_index;
    logic [DUR_W-1:0]     duration;
    logic                 run;
  } seq_cmd_t;

  typedef struct packed {
    logic [OUT_FR_W-1:0]  frame;
    logic                 playing;
    logic [OUT_POS_W-1:0] position;
  } frame_status_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  vfas_in_if  cmd_ch ();
  vfas_out_if status_ch ();

  variable_frame_animation_sequencer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (cmd_ch),
    .out_if    (status_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Predicted sequencer state
  // --------------------------------------------------------------------------
  logic [TIME_W-1:0]  end_time_tbl [MAX_FRAMES];
  bit                 end_time_valid [MAX_FRAMES];   // set once a load wrote it
  logic [TIME_W-1:0]  load_total;
  logic [TIME_W-1:0]  play_pos;
  logic [FRAME_W-1:0] cur_frame;
  logic               playing_now;
  logic [FC_W-1:0]    reg_frames;
  logic               reg_loop;
  logic [SPEED_W-1:0] reg_speed;

  frame_status_t awaited_status [$];   // one status per accepted transaction

  bit idle_on = 1'b1;        // clear for a stretch with no idling on either side
  bit long_hold_req = 1'b0;  // ask the status sink for one long stall

  int unsigned mismatch_count = 0;
  int unsigned checked_count = 0;
  int unsigned n_tick = 0, n_load = 0, n_seek = 0, n_run = 0, n_writes = 0;

  function automatic void reset_playback();
    for (int i = 0; i < MAX_FRAMES; i++) begin
      end_time_tbl[i]   = '0;
      end_time_valid[i] = 1'b0;
    end
    load_total  = '0;
    play_pos    = '0;
    cur_frame   = '0;
    playing_now = 1'b1;
    reg_frames  = 7'd1;
    reg_loop    = 1'b1;
    reg_speed   = 16'd256;
  endfunction

  // frame_count clamped to the table size, never below one
  function automatic int unsigned active_frames();
    if (reg_frames == 0) return 1;
    if (reg_frames > MAX_FRAMES) return MAX_FRAMES;
    return int'(reg_frames);
  endfunction

  // saturate a wide sum at the top of the time range
  function automatic logic [TIME_W-1:0] clip_time(input logic [63:0] s);
    if (s[63:TIME_W] != 0) return '1;
    return s[TIME_W-1:0];
  endfunction

  // frame zero starts at zero, any other frame one unit past the previous end
  function automatic void jump_to_frame(input int unsigned f);
    int unsigned n;
    n = active_frames();
    if (f >= n) f = n - 1;
    cur_frame = FRAME_W'(f);
    play_pos  = (f == 0) ? '0 : clip_time(64'(end_time_tbl[f - 1]) + 64'd1);
  endfunction

  // apply one transaction to the predicted state, return the status it yields
  function automatic frame_status_t advance_playback(input seq_cmd_t c);
    frame_status_t s;
    int unsigned   n, f;
    logic [63:0]   scaled, total;
    n = active_frames();
    case (c.cmd)
      CMD_TICK: begin
        if (playing_now) begin
          total    = 64'(end_time_tbl[n - 1]);
          scaled   = (64'(c.elapsed) * 64'(reg_speed)) >> FRAC_BITS;
          play_pos = clip_time(64'(play_pos) + scaled);
          if (play_pos > total && !reg_loop) begin
            // ran off the end with looping off: stop on the last frame
            playing_now = 1'b0;
            jump_to_frame(n - 1);
          end else begin
            f = (cur_frame >= n) ? 0 : cur_frame;
            if (reg_loop && play_pos >= total) begin
              play_pos = (total == 0) ? '0 : TIME_W'(64'(play_pos) % total);
              f = 0;
            end
            while (f < n - 1 && play_pos >= end_time_tbl[f]) f++;
            cur_frame = FRAME_W'(f);
          end
        end
      end
      CMD_LOAD: begin
        load_total = (c.frame_index == 0) ? TIME_W'(c.duration)
                                          : clip_time(64'(load_total) + 64'(c.duration));
        end_time_tbl[c.frame_index]   = load_total;
        end_time_valid[c.frame_index] = 1'b1;
      end
      CMD_SEEK: jump_to_frame(c.frame_index);
      default:  playing_now = c.run;
    endcase
    s.frame    = cur_frame;
    s.playing  = playing_now;
    s.position = play_pos;
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic seq_cmd_t random_fields();
    seq_cmd_t c;
    c.cmd         = cmd_t'($urandom_range(0, 3));
    c.elapsed     = ELAPSED_W'($urandom());
    c.frame_index = IDX_W'($urandom());
    c.duration    = DUR_W'($urandom());
    c.run         = 1'($urandom());
    return c;
  endfunction

  // mostly short frames so ticks walk several of them, plus the extremes
  function automatic logic [DUR_W-1:0] pick_duration();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return DUR_W'($urandom_range(1, 500));
    if (roll < 80) return '0;
    if (roll < 90) return '1;
    return DUR_W'($urandom());
  endfunction

  function automatic seq_cmd_t random_command();
    seq_cmd_t    c;
    int unsigned roll, n, f;
    bit          safe;
    c = random_fields();
    c.duration = pick_duration();
    roll = $urandom_range(0, 99);
    if (roll < 50) c.elapsed = ELAPSED_W'($urandom_range(0, 1023));
    else if (roll < 85) c.elapsed = ELAPSED_W'($urandom_range(0, 8191));
    roll = $urandom_range(0, 99);
    if (!playing_now && roll < 30) begin
      // restart play after a stop on 30 percent of the draws
      c.cmd = CMD_RUN;
      c.run = 1'b1;
    end else if (roll < 65) begin
      c.cmd = CMD_TICK;
    end else if (roll < 80) begin
      c.cmd = CMD_SEEK;
    end else if (roll < 88) begin
      c.cmd = CMD_RUN;
      c.run = ($urandom_range(0, 3) != 0);
    end else begin
      c.cmd = CMD_LOAD;
    end
    // never let a tick or seek read an end time that no load has set
    n = active_frames();
    safe = 1'b1;
    if (c.cmd == CMD_TICK) begin
      for (int i = 0; i < n; i++) if (!end_time_valid[i]) safe = 1'b0;
    end else if (c.cmd == CMD_SEEK) begin
      f = (c.frame_index >= n) ? n - 1 : c.frame_index;
      if (f != 0 && !end_time_valid[f - 1]) safe = 1'b0;
    end
    if (!safe) c.cmd = CMD_LOAD;
    return c;
  endfunction

  // Offer one transaction, hold it until accepted, then queue its status.
  // Called at a rising edge; returns at the edge that accepted it.
  task automatic send_command(input seq_cmd_t c);
    if (idle_on) begin
      while ($urandom_range(0, 99) < IDLE_PERCENT) begin
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.cmd         <= c.cmd;
    cmd_ch.elapsed     <= c.elapsed;
    cmd_ch.frame_index <= c.frame_index;
    cmd_ch.duration    <= c.duration;
    cmd_ch.run         <= c.run;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    awaited_status = {awaited_status, advance_playback(c)};
    case (c.cmd)
      CMD_TICK: n_tick++;
      CMD_LOAD: n_load++;
      CMD_SEEK: n_seek++;
      default:  n_run++;
    endcase
  endtask

  task automatic do_tick(input logic [ELAPSED_W-1:0] el);
    seq_cmd_t c;
    c = random_fields();
    c.cmd = CMD_TICK;
    c.elapsed = el;
    send_command(c);
  endtask

  task automatic do_load(input logic [IDX_W-1:0] idx, input logic [DUR_W-1:0] dur);
    seq_cmd_t c;
    c = random_fields();
    c.cmd = CMD_LOAD;
    c.frame_index = idx;
    c.duration = dur;
    send_command(c);
  endtask

  task automatic do_seek(input logic [IDX_W-1:0] idx);
    seq_cmd_t c;
    c = random_fields();
    c.cmd = CMD_SEEK;
    c.frame_index = idx;
    send_command(c);
  endtask

  task automatic do_run(input logic r);
    seq_cmd_t c;
    c = random_fields();
    c.cmd = CMD_RUN;
    c.run = r;
    send_command(c);
  endtask

  // Drop valid and wait until every queued status has come back. Each
  // transaction yields exactly one status, so the block is idle after that;
  // pad the wait for the return to the dispatch step.
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    while (awaited_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    settle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_writes++;
    case (idx)
      CFG_FRAME_COUNT: reg_frames = value[FC_W-1:0];
      CFG_LOOP_ENABLE: reg_loop   = value[0];
      CFG_SPEED:       reg_speed  = value[SPEED_W-1:0];
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Reset settings: one frame, looping, unit speed. Land exactly on the
  // total so the wrap must fire on equality, not only beyond it.
  task automatic test_load_and_exact_wrap();
    do_load(6'd0, 16'd100);
    do_tick(16'd100);
  endtask

  // Four frames, the third of zero length. Walk across several ends in one
  // tick, seek in and out of range, and wrap a long tick modulo the total.
  task automatic test_seek_and_walk();
    write_reg(CFG_FRAME_COUNT, 16'd4);
    do_load(6'd0, 16'd10);
    do_load(6'd1, 16'd20);
    do_load(6'd2, 16'd0);
    do_load(6'd3, 16'd15);
    do_load(6'd63, 16'hFFFF);   // beyond the frames in use; stored, never read
    do_tick(16'd5);
    do_tick(16'd25);
    do_seek(6'd2);
    do_seek(6'd63);
    do_seek(6'd0);
    do_tick(16'hFFFF);
  endtask

  // Stopped ticks change nothing; check speed scaling at the extremes and
  // with truncation, then run off the end with looping off.
  task automatic test_speed_and_stop();
    do_run(1'b0);
    do_tick(16'd100);
    do_run(1'b1);
    write_reg(CFG_SPEED, 16'hFFFF);
    do_tick(16'hFFFF);
    write_reg(CFG_SPEED, 16'd0);
    do_tick(16'd1000);
    write_reg(CFG_SPEED, 16'd128);
    write_reg(CFG_SPARE, 16'd0);   // must not touch speed or anything else
    do_tick(16'd3);
    write_reg(CFG_LOOP_ENABLE, 16'd0);
    write_reg(CFG_SPEED, 16'd256);
    do_tick(16'hFFFF);
  endtask

  // Shrink frame_count below the frame play stopped on; the next tick must
  // restart the walk at frame zero.
  task automatic test_frame_count_shrink();
    write_reg(CFG_FRAME_COUNT, 16'd2);
    write_reg(CFG_LOOP_ENABLE, 16'd1);
    do_run(1'b1);
    do_load(6'd0, 16'd50);
    do_load(6'd1, 16'd50);
    do_tick(16'd0);
  endtask

  // A zero total: looping pins the position at zero, no looping stops play.
  task automatic test_zero_total();
    write_reg(CFG_FRAME_COUNT, 16'd1);
    do_load(6'd0, 16'd0);
    do_tick(16'd5);
    write_reg(CFG_LOOP_ENABLE, 16'd0);
    do_tick(16'd5);
  endtask

  // --------------------------------------------------------------------------
  // Random playback under one register setting: load every frame in use in
  // order, then mix ticks, seeks, run writes and reloads.
  // --------------------------------------------------------------------------
  task automatic test_random_playback(input logic [FC_W-1:0]    frames,
                                      input logic               loop,
                                      input logic [SPEED_W-1:0] spd,
                                      input int unsigned        count,
                                      input bit                 squeeze = 1'b0);
    int unsigned n;
    // random upper bits: only the low bits of each register are kept
    write_reg(CFG_FRAME_COUNT, {9'($urandom()), frames});
    write_reg(CFG_LOOP_ENABLE, {15'($urandom()), loop});
    write_reg(CFG_SPEED, spd);
    n = active_frames();
    for (int i = 0; i < n; i++) do_load(IDX_W'(i), pick_duration());
    if (squeeze) long_hold_req = 1'b1;
    for (int i = n; i < count; i++) send_command(random_command());
  endtask

  task automatic test_no_idle_stretch();
    settle();
    idle_on = 1'b0;
    test_random_playback(7'd12, 1'b1, 16'd384, 120);
    settle();
    idle_on = 1'b1;
  endtask

  // Hold the status sink off for a long time while commands keep coming, so
  // the block backs up and stalls the command channel.
  task automatic test_output_backpressure();
    test_random_playback(7'd5, 1'b1, 16'd256, 60, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Clock, status sink and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Pop the oldest expectation for every status transaction and compare it
  // field by field; drive ready for the next edge.
  initial begin : status_sink
    int unsigned   hold_left;
    frame_status_t got, want;
    hold_left = 0;
    status_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && status_ch.valid && status_ch.ready) begin
        got.frame    = status_ch.frame;
        got.playing  = status_ch.playing;
        got.position = status_ch.position;
        if (awaited_status.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] status with nothing pending: %0d/%0b/%0d", $time,
                     got.frame, got.playing, got.position);
        end else begin
          want = awaited_status.pop_front();
          checked_count++;
          if (got.frame !== want.frame || got.playing !== want.playing ||
              got.position !== want.position) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("[%0t] status mismatch (frame/playing/position): %s%0d/%0b/%0d, %s%0d/%0b/%0d",
                       $time, "expected ", want.frame, want.playing, want.position,
                       "got ", got.frame, got.playing, got.position);
          end
        end
      end
      // count down a long stall here, then fall back to random idling
      if (hold_left != 0) begin
        hold_left--;
        status_ch.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        status_ch.ready <= 1'b0;
      end else begin
        status_ch.ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  initial begin : watchdog
    #4000000;
    $display("Timeout waiting for the sequencer");
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_FRAME_COUNT;
    cfg_wdata          = '0;
    cmd_ch.valid       = 1'b0;
    cmd_ch.cmd         = CMD_TICK;
    cmd_ch.elapsed     = '0;
    cmd_ch.frame_index = '0;
    cmd_ch.duration    = '0;
    cmd_ch.run         = 1'b0;
    reset_playback();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_load_and_exact_wrap();
    test_seek_and_walk();
    test_speed_and_stop();
    test_frame_count_shrink();
    test_zero_total();

    // extremes of every register first, then random settings
    test_random_playback(7'd64, 1'b1, 16'd256, 150);
    test_random_playback(7'd1, 1'b1, 16'd256, 60);
    test_random_playback(7'd8, 1'b0, 16'd256, 100);
    test_random_playback(7'd2, 1'b1, 16'hFFFF, 80);
    test_random_playback(7'd16, 1'b1, 16'd0, 50);
    test_random_playback(7'd127, 1'b0, 16'd512, 120);
    test_random_playback(7'd0, 1'b0, 16'd1, 50);
    repeat (4)
      test_random_playback(FC_W'($urandom_range(1, MAX_FRAMES)), 1'($urandom()),
                           SPEED_W'($urandom()), 80);
    test_no_idle_stretch();
    test_output_backpressure();

    // drain, then leave room for any stray status transaction
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d commands: %0d ticks, %0d loads, %0d seeks, %0d run-flag writes",
             n_tick + n_load + n_seek + n_run, n_tick, n_load, n_seek, n_run);
    $display("Made %0d register writes; checked %0d statuses, %0d mismatches",
             n_writes, checked_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
